/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/aie_pkg.sv */
// Types, opcodes and helpers for the accumulator instruction execute block.
// No dependencies.
`default_nettype none

package aie_pkg;

  localparam int unsigned RegW  = 32;
  localparam int unsigned NumW  = 31;
  localparam int unsigned RselW = 3;
  localparam int unsigned KindW = 4;
  localparam int unsigned StW   = 2;
  localparam int unsigned OutPcW = 16;

  typedef enum logic [KindW-1:0] {
    OP_MV  = 4'd0,
    OP_MI  = 4'd1,
    OP_AD  = 4'd2,
    OP_SB  = 4'd3,
    OP_MP  = 4'd4,
    OP_JC  = 4'd5,
    OP_JZ  = 4'd6,
    OP_JL  = 4'd7,
    OP_JP  = 4'd8,
    OP_JM  = 4'd9,
    OP_PR  = 4'd10,
    OP_IC  = 4'd11,
    OP_DC  = 4'd12,
    OP_EX  = 4'd13,
    OP_NOP = 4'd14,
    OP_UNK = 4'd15
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE  = 2'd0,
    ST_PRINT = 2'd1,
    ST_END   = 2'd2,
    ST_ERR   = 2'd3
  } status_e;

  // Register select codes
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;

  typedef struct packed {
    op_e              kind;
    logic [RselW-1:0] first_reg;
    logic [RselW-1:0] second_reg;
    logic             has_number;
    logic [NumW-1:0]  number;
  } item_t;

  typedef struct packed {
    logic [RegW-1:0] reg_a;
    logic [RegW-1:0] reg_b;
    logic [RegW-1:0] reg_c;
    logic [RegW-1:0] reg_d;
  } regs_t;

  // One register write per instruction at most
  typedef struct packed {
    logic            en;
    logic [1:0]      idx;
    logic [RegW-1:0] data;
  } wr_t;

  function automatic logic [RegW-1:0] read_reg(regs_t r, logic [1:0] idx);
    logic [RegW-1:0] v;
    case (idx)
      REG_A:   v = r.reg_a;
      REG_B:   v = r.reg_b;
      REG_C:   v = r.reg_c;
      REG_D:   v = r.reg_d;
      default: v = r.reg_a;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/aie_state.sv */
// Architectural state: registers A..D and the program counter.
// Depends on aie_pkg.
`default_nettype none

module aie_state import aie_pkg::*; #(
  parameter int unsigned PC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  wr_t                wr_i,
  input  logic [PC_BITS-1:0] pc_d_i,
  output regs_t              regs_o,
  output logic [PC_BITS-1:0] pc_o
);

  regs_t              regs_q, regs_d;
  logic [PC_BITS-1:0] pc_q;

  always_comb begin
    regs_d = regs_q;
    if (wr_i.en) begin
      case (wr_i.idx)
        REG_A:   regs_d.reg_a = wr_i.data;
        REG_B:   regs_d.reg_b = wr_i.data;
        REG_C:   regs_d.reg_c = wr_i.data;
        REG_D:   regs_d.reg_d = wr_i.data;
        default: regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
      pc_q   <= '0;
    end else if (commit_i) begin
      regs_q <= regs_d;
      pc_q   <= pc_d_i;
    end
  end

  assign regs_o = regs_q;
  assign pc_o   = pc_q;

endmodule

`default_nettype wire

/* rtl/aie_exec.sv */
// Single-pass execute logic: decode, operand select, ALU, branch resolve.
// Depends on aie_pkg.
`default_nettype none

module aie_exec import aie_pkg::*; #(
  parameter int unsigned PC_BITS = 16
) (
  input  item_t              item_i,
  input  regs_t              regs_i,
  input  logic [PC_BITS-1:0] pc_i,
  output wr_t                wr_o,
  output logic [PC_BITS-1:0] pc_o,
  output status_e            status_o,
  output logic [RegW-1:0]    pval_o
);

  logic            r1_ok, r2_ok, use_reg;
  logic [RegW-1:0] op1, op2, opnd, imm, acc, c_val;
  logic [RegW-1:0] sum, diff, prod;
  logic [PC_BITS-1:0] pc_inc, target;
  logic            take;

  assign r1_ok  = !item_i.first_reg[2];
  assign r2_ok  = !item_i.second_reg[2];
  assign op1    = read_reg(regs_i, item_i.first_reg[1:0]);
  assign op2    = read_reg(regs_i, item_i.second_reg[1:0]);
  assign imm    = RegW'(item_i.number);
  assign acc    = regs_i.reg_a;
  assign c_val  = regs_i.reg_c;
  assign pc_inc = pc_i + PC_BITS'(1);
  assign target = PC_BITS'(item_i.number);

  // D is not an operand for add/subtract, only for multiply
  assign use_reg = (item_i.kind == OP_MP) ? r1_ok
                                          : (item_i.first_reg < RselW'(REG_D));
  assign opnd    = use_reg ? op1 : imm;
  assign sum     = acc + opnd;
  assign diff    = acc - opnd;
  assign prod    = RegW'(acc * opnd);

  always_comb begin
    case (item_i.kind)
      OP_JC:   take = (c_val != '0);
      OP_JZ:   take = (c_val == '0);
      OP_JL:   take = c_val[RegW-1];
      OP_JP:   take = 1'b1;
      OP_JM:   take = (c_val != '0) && !c_val[RegW-1];
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    wr_o     = '0;
    pc_o     = pc_inc;
    status_o = ST_DONE;
    pval_o   = '0;
    case (item_i.kind)
      OP_MV: begin
        if (r1_ok && r2_ok) begin
          wr_o = '{en: 1'b1, idx: item_i.first_reg[1:0], data: op2};
        end else begin
          status_o = ST_ERR;
        end
      end
      OP_MI: begin
        if (r1_ok && item_i.has_number) begin
          wr_o = '{en: 1'b1, idx: item_i.first_reg[1:0], data: imm};
        end else begin
          status_o = ST_ERR;
        end
      end
      OP_AD, OP_SB, OP_MP: begin
        if (use_reg || item_i.has_number) begin
          wr_o.en  = 1'b1;
          wr_o.idx = REG_A;
          case (item_i.kind)
            OP_AD:   wr_o.data = sum;
            OP_SB:   wr_o.data = diff;
            default: wr_o.data = prod;
          endcase
        end else begin
          status_o = ST_ERR;
        end
      end
      OP_JC, OP_JZ, OP_JL, OP_JP, OP_JM: begin
        if (!item_i.has_number) begin
          status_o = ST_ERR;
        end else if (take) begin
          pc_o = target;
        end
      end
      OP_PR: begin
        if (r1_ok) begin
          status_o = ST_PRINT;
          pval_o   = op1;
        end else begin
          status_o = ST_ERR;
        end
      end
      OP_IC, OP_DC: begin
        if (r1_ok) begin
          wr_o.en   = 1'b1;
          wr_o.idx  = item_i.first_reg[1:0];
          wr_o.data = (item_i.kind == OP_IC) ? op1 + RegW'(1) : op1 - RegW'(1);
        end else begin
          status_o = ST_ERR;
        end
      end
      OP_EX:   status_o = ST_END;
      OP_NOP:  status_o = ST_DONE;
      default: status_o = ST_ERR;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/accumulator_instruction_execute.sv */
// Accumulator machine, one decoded instruction per request.
// Path: input register, then execute into the result register and the
//   architectural state; a held result register stalls the execute step.
// Throughput: 1 request per cycle while the result is taken; the execute pass
//   is bounded by the 32x32 multiply feeding register A.
// Reset: asynchronous, clears A..D, the program counter and both valid flags.
`default_nettype none
`include "assert_macros.svh"

module accumulator_instruction_execute import aie_pkg::*; #(
  parameter int unsigned PC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [KindW-1:0]       kind_i,
  input  logic [RselW-1:0]       first_reg_i,
  input  logic [RselW-1:0]       second_reg_i,
  input  logic                   has_number_i,
  input  logic [NumW-1:0]        number_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [StW-1:0]         status_o,
  output logic signed [RegW-1:0] print_value_o,
  output logic [OutPcW-1:0]      next_pc_o
);

  // Input register stage
  logic  in_valid_q;
  item_t item_q;
  logic  in_fire, exec_fire;

  // Result register stage
  logic                out_valid_q;
  status_e             status_q;
  logic [RegW-1:0]     pval_q;
  logic [OutPcW-1:0]   next_pc_q;

  // Execute <-> state
  regs_t              regs;
  logic [PC_BITS-1:0] pc_q;
  logic [PC_BITS-1:0] pc_d;
  wr_t                wr;
  status_e            exec_status;
  logic [RegW-1:0]    exec_pval;
  logic               jump_op;

  // An item in the input register executes when the result register is
  // free or is being drained in this cycle; state commits on the same edge,
  // so the following request sees the updated registers without forwarding.
  assign exec_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || exec_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (exec_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{kind:       op_e'(kind_i),
                  first_reg:  first_reg_i,
                  second_reg: second_reg_i,
                  has_number: has_number_i,
                  number:     number_i};
    end
  end

  aie_exec #(
    .PC_BITS (PC_BITS)
  ) u_exec (
    .item_i   (item_q),
    .regs_i   (regs),
    .pc_i     (pc_q),
    .wr_o     (wr),
    .pc_o     (pc_d),
    .status_o (exec_status),
    .pval_o   (exec_pval)
  );

  aie_state #(
    .PC_BITS (PC_BITS)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (exec_fire),
    .wr_i     (wr),
    .pc_d_i   (pc_d),
    .regs_o   (regs),
    .pc_o     (pc_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q  <= exec_status;
      pval_q    <= exec_pval;
      next_pc_q <= OutPcW'(pc_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign print_value_o = pval_q;
  assign next_pc_o     = next_pc_q;

  assign jump_op = (item_q.kind == OP_JC) || (item_q.kind == OP_JZ) ||
                   (item_q.kind == OP_JL) || (item_q.kind == OP_JP) ||
                   (item_q.kind == OP_JM);

  // Non-jump requests only step the counter by one
  `ASSERT_PROP(a_pc_step, clk_i, rst_ni,
    (exec_fire && !jump_op) |=> (pc_q == $past(pc_q) + PC_BITS'(1)),
    "pc did not advance by one on a non-jump request")

  // Errored requests leave the register file alone
  `ASSERT_NEVER(a_err_no_write, clk_i, rst_ni,
    exec_fire && (exec_status == ST_ERR) && wr.en,
    "register write on an errored request")

  // Reported counter matches the committed counter
  `ASSERT_PROP(a_pc_report, clk_i, rst_ni,
    exec_fire |=> (next_pc_q == OutPcW'(pc_q)),
    "reported next_pc differs from the committed counter")

endmodule

`default_nettype wire
